### rtl/cdg_pkg.sv
package cdg_pkg;

  // Frame geometry limits and pixel depth
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int DIM_BITS  = 11;
  localparam int GRAD_BITS = PIXEL_BITS + 1;

  // Configuration register map
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

  // Zero reads as one, anything above the limit reads as the limit
  function automatic logic [DIM_BITS-1:0] dim_clamp(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] maxv);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/cdg_pix_if.sv
interface cdg_pix_if
  import cdg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### rtl/cdg_grad_if.sv
interface cdg_grad_if
  import cdg_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [GRAD_BITS-1:0] grad_horizontal;
  logic signed [GRAD_BITS-1:0] grad_vertical;
  logic                        run_last;
  logic                        frame_last;

  modport source (output valid, output grad_horizontal, output grad_vertical,
                  output run_last, output frame_last, input ready);
  modport sink   (input valid, input grad_horizontal, input grad_vertical,
                  input run_last, input frame_last, output ready);
endinterface

### rtl/cdg_cfg_if.sv
interface cdg_cfg_if
  import cdg_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DIM_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cdg_ram.sv
// Single-port RAM, read-first, registered read data held while en is low
module cdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule

### rtl/central_difference_gradient.sv
// Channel  | Dir | Payload                                              | Transaction
// ---------+-----+------------------------------------------------------+------------------
// in_pix   | in  | pixel[7:0]                                           | valid & ready
// out_grad | out | grad_horizontal[8:0] s, grad_vertical[8:0] s,        | valid & ready
//          |     | run_last, frame_last                                 |
// cfg_wr   | in  | index[1:0] (0 width, 1 height), data[10:0]           | valid & ready
//
// One pixel per cycle on rows other than the last while out_grad is not stalled; last-row
// pixels below row 0 give two results each, and stage 1 holds such a pixel until both go.
// Results pass from stage 1 through the output register to out_grad.
// Synchronous active-low reset; no line-store clearing pass. cfg_wr is
// always ready. Either side may stall freely; the block holds one pixel in stage 1
// and one result in the output register.
module central_difference_gradient
  import cdg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cdg_pix_if.sink      in_pix,
  cdg_grad_if.source   out_grad,
  cdg_cfg_if.sink      cfg_wr
);

  // ---------------------------------------------------------------------------
  // Configuration registers (stored clamped)
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0] width_r;
  logic [DIM_BITS-1:0] height_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_IMAGE_WIDTH:  width_r  <= dim_clamp(cfg_wr.data, DIM_BITS'(MAX_WIDTH));
        REG_IMAGE_HEIGHT: height_r <= dim_clamp(cfg_wr.data, DIM_BITS'(MAX_HEIGHT));
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front: counters and line-store access at the input transaction
  // ---------------------------------------------------------------------------
  logic [COL_BITS-1:0] col_r, col_nxt, col_inc;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic                last_col, last_row;
  logic                accept;
  logic                in_ready;

  assign accept   = in_pix.valid && in_ready;
  assign in_pix.ready = in_ready;

  assign last_col = {1'b0, col_r} >= (width_r - DIM_BITS'(1));
  assign last_row = ({{(DIM_BITS-ROW_BITS){1'b0}}, row_r}) >= (height_r - DIM_BITS'(1));
  assign col_inc  = col_r + COL_BITS'(1);

  always_comb begin
    col_nxt = col_inc;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Two line stores by row parity. The current row's store is read then written at
  // the same column (gives the pixel two rows up); the other store is read one
  // column ahead (right neighbour of the row being emitted).
  logic                  par;
  logic [COL_BITS-1:0]   addr_even, addr_odd;
  logic [PIXEL_BITS-1:0] rd_even, rd_odd;

  assign par       = row_r[0];
  assign addr_even = par ? col_inc : col_r;
  assign addr_odd  = par ? col_r : col_inc;

  cdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_even (
    .clk   (clk),
    .en    (accept),
    .we    (accept && !par),
    .addr  (addr_even),
    .wdata (in_pix.pixel),
    .rdata (rd_even)
  );

  cdg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_odd (
    .clk   (clk),
    .en    (accept),
    .we    (accept && par),
    .addr  (addr_odd),
    .wdata (in_pix.pixel),
    .rdata (rd_odd)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: one pixel with its line-store data
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic                  s1_par_r;
  logic                  s1_border_r;   // emitted pixel on first/last column or row 0
  logic                  s1_emit_a_r;   // result for the pixel above
  logic                  s1_emit_b_r;   // own zero result (last row)
  logic                  s1_last_col_r;
  logic                  s1_col0_r;
  logic                  s1_col1_r;
  logic                  s1_phase_r;    // set once the result above has gone

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_pix.pixel;
      s1_par_r      <= par;
      s1_border_r   <= (col_r == '0) || last_col || (row_r == ROW_BITS'(1));
      s1_emit_a_r   <= (row_r != '0);
      s1_emit_b_r   <= last_row;
      s1_last_col_r <= last_col;
      s1_col0_r     <= (col_r == '0);
      s1_col1_r     <= (col_r == COL_BITS'(1));
    end
  end

  // Neighbours of the row being emitted: right comes from the store, left from the
  // right reads two pixels back, or from the row's first pixel at column one.
  logic [PIXEL_BITS-1:0] hist1_r, hist2_r;
  logic [PIXEL_BITS-1:0] cur_first_r, prev_first_r;
  logic [PIXEL_BITS-1:0] above, right, left;
  logic [GRAD_BITS-1:0]  gh, gv;

  assign above = s1_par_r ? rd_odd : rd_even;
  assign right = s1_par_r ? rd_even : rd_odd;
  assign left  = s1_col1_r ? prev_first_r : hist2_r;
  assign gh    = {1'b0, right} - {1'b0, left};
  assign gv    = {1'b0, s1_pix_r} - {1'b0, above};

  logic show_a, show_b, has_res, out_free, move, s1_done;

  assign show_a   = s1_emit_a_r && !s1_phase_r;
  assign show_b   = s1_emit_b_r && (s1_phase_r || !s1_emit_a_r);
  assign has_res  = s1_valid_r && (show_a || show_b);
  assign out_free = !out_grad.valid || out_grad.ready;
  assign move     = has_res && out_free;
  assign s1_done  = s1_valid_r && (!has_res || (move && !(show_a && s1_emit_b_r)));
  assign in_ready = !s1_valid_r || s1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_phase_r <= 1'b0;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end else if (move) begin
        s1_phase_r <= 1'b1;   // first of two results gone
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      hist2_r <= hist1_r;
      hist1_r <= right;
      if (s1_col0_r) begin
        prev_first_r <= cur_first_r;
        cur_first_r  <= s1_pix_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                        out_valid_r;
  logic signed [GRAD_BITS-1:0] out_gh_r, out_gv_r;
  logic                        out_rl_r, out_fl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_grad.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      if (show_a) begin
        out_gh_r <= s1_border_r ? '0 : $signed(gh);
        out_gv_r <= s1_border_r ? '0 : $signed(gv);
        out_rl_r <= !s1_emit_b_r;
        out_fl_r <= 1'b0;
      end else begin
        out_gh_r <= '0;
        out_gv_r <= '0;
        out_rl_r <= 1'b1;
        out_fl_r <= s1_last_col_r;
      end
    end
  end

  assign out_grad.valid           = out_valid_r;
  assign out_grad.grad_horizontal = out_gh_r;
  assign out_grad.grad_vertical   = out_gv_r;
  assign out_grad.run_last        = out_rl_r;
  assign out_grad.frame_last      = out_fl_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_frame_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fl_r |-> out_rl_r)
    else $error("frame_last without run_last");

  a_frame_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fl_r |-> (out_gh_r == '0) && (out_gv_r == '0))
    else $error("frame end result not zero");

  a_phase_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_phase_r |-> s1_emit_a_r && s1_emit_b_r)
    else $error("second phase on a single-result pixel");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule
